// File: rtl/uac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package uac_pkg;

	localparam int LONGEST_PATTERN_DEF = 15;
	localparam int OS_COUNT  = 15;
	localparam int BRW_COUNT = 21;
	localparam int PAT_BYTES = 15;
	localparam int OS_CODE_W  = 4;
	localparam int BRW_CODE_W = 5;
	localparam int POS_W      = 5;

	typedef logic [8*PAT_BYTES-1:0] pat_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [OS_CODE_W-1:0]  os_code;
		logic [BRW_CODE_W-1:0] browser_code;
	} out_beat_t;

	typedef struct packed {
		logic [OS_COUNT-1:0]  os;
		logic [BRW_COUNT-1:0] brw;
	} match_t;

	// Patterns are ASCII, right-justified: byte 0 is the final character.
	localparam pat_t OS_PAT [OS_COUNT] = '{
		120'h57696E646F7773204E5420362E32,
		120'h57696E646F7773204E5420362E31,
		120'h57696E646F7773204E5420362E30,
		120'h57696E646F7773204E5420352E31,
		120'h57696E646F7773204E5420352E30,
		120'h57696E646F7773204E5420352E32,
		120'h57696E646F7773204E5420342E30,
		120'h57696E20397820342E39,
		120'h57696E646F7773203938,
		120'h69506164,
		120'h6950686F6E65,
		120'h4D6163,
		120'h416E64726F6964,
		120'h476F6F676C6520576562,
		120'h4C696E7578
	};

	localparam pos_t OS_LEN [OS_COUNT] = '{
		5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd10,
		5'd10, 5'd4, 5'd6, 5'd3, 5'd7, 5'd10, 5'd5
	};

	localparam logic [OS_CODE_W-1:0] OS_CODE [OS_COUNT] = '{
		4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
		4'd9, 4'd10, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14
	};

	localparam pat_t BRW_PAT [BRW_COUNT] = '{
		120'h3336305345,
		120'h4368726F6D65,
		120'h46697265666F78,
		120'h4D6F7A696C6C61,
		120'h536166617269,
		120'h54656E63656E7454726176656C6572,
		120'h4B6F6E717565726F72,
		120'h4E6176696761746F72,
		120'h4E65747363617065,
		120'h4F70657261,
		120'h49452039,
		120'h49452038,
		120'h49452037,
		120'h49452036,
		120'h49452035,
		120'h49452034,
		120'h49452033,
		120'h534520322E58204D6574615372,
		120'h546865576F726C64,
		120'h4D617874686F6E,
		120'h4D79494532
	};

	localparam pos_t BRW_LEN [BRW_COUNT] = '{
		5'd5, 5'd6, 5'd7, 5'd7, 5'd6, 5'd15, 5'd9, 5'd9,
		5'd8, 5'd5, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4,
		5'd4, 5'd13, 5'd8, 5'd7, 5'd5
	};

	// Per-pattern compare of one window byte; positions past a pattern's end pass.
	function automatic match_t match_byte(logic [7:0] b, pos_t pos);
		match_t     m;
		logic [3:0] idx;
		idx = pos[3:0];
		for (int p = 0; p < OS_COUNT; p++) begin
			if (pos >= OS_LEN[p]) begin
				m.os[p] = 1'b1;
			end else begin
				m.os[p] = (b == OS_PAT[p][8*idx +: 8]);
			end
		end
		for (int p = 0; p < BRW_COUNT; p++) begin
			if (pos >= BRW_LEN[p]) begin
				m.brw[p] = 1'b1;
			end else begin
				m.brw[p] = (b == BRW_PAT[p][8*idx +: 8]);
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// File: rtl/uac_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface uac_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/uac_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module uac_cell #(
	parameter int POS = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift,
	input  wire logic          clear,
	input  wire logic [7:0]    d,
	output logic [7:0]         q,
	output uac_pkg::match_t    hit
);

	logic [7:0] hist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (clear) begin
			hist_q <= '0;
		end else if (shift) begin
			hist_q <= d;
		end
	end

	assign q = hist_q;

	always_comb begin
		hit = uac_pkg::match_byte(hist_q, uac_pkg::pos_t'(POS));
	end

endmodule
`default_nettype wire

// File: rtl/uac_encode.sv
`timescale 1ns / 1ps
`default_nettype none
module uac_encode (
	input  wire uac_pkg::match_t found,
	output uac_pkg::out_beat_t   codes
);

	// Lowest set bit wins: scan from the top so the lowest index is written last.
	always_comb begin
		codes.os_code      = '0;
		codes.browser_code = '0;
		for (int i = uac_pkg::OS_COUNT - 1; i >= 0; i--) begin
			if (found.os[i]) begin
				codes.os_code = uac_pkg::OS_CODE[i];
			end
		end
		for (int i = uac_pkg::BRW_COUNT - 1; i >= 0; i--) begin
			if (found.brw[i]) begin
				codes.browser_code = uac_pkg::BRW_CODE_W'(i + 1);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/user_agent_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// Classifies a user-agent string fed one byte per beat on text_in; the beat
// with last_byte set yields one beat on class_out carrying an OS code and a
// browser code (0 when nothing matched), registered when that byte is taken.
// Unless stalled, a byte is taken every cycle: the incoming byte and the
// LONGEST_PATTERN-1 history cells are compared in parallel against the whole
// pattern table, and the hits fold into sticky per-pattern bits. text_in stalls
// only while a finished result is held and class_out is not ready. A zero byte
// stops matching for the rest of the string. State clears with the last byte;
// there is no clearing pass after reset.
module user_agent_classifier #(
	parameter int LONGEST_PATTERN = uac_pkg::LONGEST_PATTERN_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	uac_stream_if.sink   text_in,
	uac_stream_if.source class_out
);

	localparam int HIST_DEPTH = LONGEST_PATTERN - 1;

	uac_pkg::in_beat_t  in_beat;
	uac_pkg::match_t    cell_hit [HIST_DEPTH];
	logic [7:0]         cell_q   [HIST_DEPTH];
	uac_pkg::match_t    window_hit;
	uac_pkg::match_t    found_q;
	uac_pkg::match_t    found_next;
	uac_pkg::out_beat_t codes;
	uac_pkg::out_beat_t out_q;
	logic               out_valid_q;
	logic               ended_q;
	logic               in_acc;
	logic               active;
	logic               shift;
	logic               clear;

	assign in_beat       = text_in.payload;
	assign text_in.ready = !out_valid_q || class_out.ready;
	assign in_acc        = text_in.valid && text_in.ready;
	assign active        = !ended_q && (in_beat.text_byte != 8'd0);
	assign shift         = in_acc && active;
	assign clear         = in_acc && in_beat.last_byte;

	for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
		logic [7:0] d;
		if (k == 0) begin : g_head
			assign d = in_beat.text_byte;
		end else begin : g_body
			assign d = cell_q[k-1];
		end
		uac_cell #(
			.POS (k + 1)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.clear  (clear),
			.d      (d),
			.q      (cell_q[k]),
			.hit    (cell_hit[k])
		);
	end

	always_comb begin
		window_hit = uac_pkg::match_byte(in_beat.text_byte, '0);
		for (int k = 0; k < HIST_DEPTH; k++) begin
			window_hit.os  = window_hit.os & cell_hit[k].os;
			window_hit.brw = window_hit.brw & cell_hit[k].brw;
		end
		found_next = found_q;
		if (active) begin
			found_next.os  = found_q.os | window_hit.os;
			found_next.brw = found_q.brw | window_hit.brw;
		end
	end

	uac_encode u_encode (
		.found (found_next),
		.codes (codes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
			ended_q <= 1'b0;
		end else if (clear) begin
			found_q <= '0;
			ended_q <= 1'b0;
		end else if (in_acc) begin
			found_q <= found_next;
			if (in_beat.text_byte == 8'd0) begin
				ended_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (clear) begin
			out_valid_q <= 1'b1;
		end else if (class_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			out_q <= codes;
		end
	end

	assign class_out.valid   = out_valid_q;
	assign class_out.payload = out_q;

	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_acc && in_beat.last_byte))
		else $error("result beat without a last byte");

	a_cleared_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (found_q == '0) && !ended_q)
		else $error("match state not cleared after last byte");

	a_hist_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(ended_q && !clear) |=> $stable(cell_q[0]))
		else $error("history moved after string end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !class_out.ready) |=> $stable(out_q) && out_valid_q)
		else $error("held result lost");

	a_os_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.os_code <= 4'd14))
		else $error("os code out of range");

endmodule
`default_nettype wire

// File: tb/sv/tb_user_agent_classifier.sv
`timescale 1ns / 1ps
module tb_user_agent_classifier;
	import uac_pkg::*;

	localparam int HIST_DEPTH = LONGEST_PATTERN_DEF - 1;
	localparam int TEXT_ITEMS = 1350;

	// Pattern text, right-justified: byte 0 holds the final character.
	localparam logic [119:0] OS_TEXT [OS_COUNT] = '{
		120'h57696E646F7773204E5420362E32,
		120'h57696E646F7773204E5420362E31,
		120'h57696E646F7773204E5420362E30,
		120'h57696E646F7773204E5420352E31,
		120'h57696E646F7773204E5420352E30,
		120'h57696E646F7773204E5420352E32,
		120'h57696E646F7773204E5420342E30,
		120'h57696E20397820342E39,
		120'h57696E646F7773203938,
		120'h69506164,
		120'h6950686F6E65,
		120'h4D6163,
		120'h416E64726F6964,
		120'h476F6F676C6520576562,
		120'h4C696E7578
	};

	localparam logic [OS_CODE_W-1:0] OS_CODE_OF [OS_COUNT] = '{
		4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
		4'd9, 4'd10, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14
	};

	localparam logic [119:0] BRW_TEXT [BRW_COUNT] = '{
		120'h3336305345,
		120'h4368726F6D65,
		120'h46697265666F78,
		120'h4D6F7A696C6C61,
		120'h536166617269,
		120'h54656E63656E7454726176656C6572,
		120'h4B6F6E717565726F72,
		120'h4E6176696761746F72,
		120'h4E65747363617065,
		120'h4F70657261,
		120'h49452039,
		120'h49452038,
		120'h49452037,
		120'h49452036,
		120'h49452035,
		120'h49452034,
		120'h49452033,
		120'h534520322E58204D6574615372,
		120'h546865576F726C64,
		120'h4D617874686F6E,
		120'h4D79494532
	};

	function automatic int pat_chars(logic [119:0] pat);
		int n;
		n = 0;
		while (n < PAT_BYTES && pat[8*n +: 8] != 8'h00) n++;
		return n;
	endfunction

	class ua_code_book;
		bit [7:0]           recent [HIST_DEPTH];
		bit [OS_COUNT-1:0]  os_seen;
		bit [BRW_COUNT-1:0] brw_seen;
		bit                 text_ended;
		out_beat_t          pending_codes [$];
		int                 mismatches;

		function new();
			clear();
			mismatches = 0;
		endfunction

		function void clear();
			foreach (recent[k]) recent[k] = 8'h00;
			os_seen = '0;
			brw_seen = '0;
			text_ended = 1'b0;
		endfunction

		// recent[0] is the newest byte; cleared cells never match a pattern byte.
		function bit ends_with(logic [119:0] pat, bit [7:0] cur);
			int n;
			n = pat_chars(pat);
			if (pat[7:0] != cur) return 1'b0;
			for (int k = 0; k + 1 < n; k++) begin
				if (recent[k] != pat[8*(k+1) +: 8]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void take_byte(in_beat_t beat);
			out_beat_t codes;
			if (!text_ended) begin
				if (beat.text_byte == 8'h00) begin
					text_ended = 1'b1;
				end else begin
					for (int p = 0; p < OS_COUNT; p++) begin
						if (ends_with(OS_TEXT[p], beat.text_byte)) os_seen[p] = 1'b1;
					end
					for (int p = 0; p < BRW_COUNT; p++) begin
						if (ends_with(BRW_TEXT[p], beat.text_byte)) brw_seen[p] = 1'b1;
					end
					for (int k = HIST_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
					recent[0] = beat.text_byte;
				end
			end
			if (beat.last_byte) begin
				codes = '0;
				// walk backwards so the lowest table index wins
				for (int p = OS_COUNT - 1; p >= 0; p--) begin
					if (os_seen[p]) codes.os_code = OS_CODE_OF[p];
				end
				for (int p = BRW_COUNT - 1; p >= 0; p--) begin
					if (brw_seen[p]) codes.browser_code = BRW_CODE_W'(p + 1);
				end
				pending_codes.push_back(codes);
				clear();
			end
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_codes(out_beat_t got);
			out_beat_t want;
			if (pending_codes.size() == 0) begin
				report_mismatch("class beat with no string pending");
				return;
			end
			want = pending_codes.pop_front();
			if (got.os_code !== want.os_code) begin
				report_mismatch($sformatf("os_code got %0d want %0d", got.os_code, want.os_code));
			end
			if (got.browser_code !== want.browser_code) begin
				report_mismatch($sformatf("browser_code got %0d want %0d",
					got.browser_code, want.browser_code));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	uac_stream_if #(.T(in_beat_t))  text_in_if ();
	uac_stream_if #(.T(out_beat_t)) class_out_if ();

	user_agent_classifier i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in_if),
		.class_out(class_out_if)
	);

	ua_code_book book;
	logic [7:0]  text_buf [$];
	int          items_sent;
	int          bytes_taken;
	bit          held_off;
	bit          drained_once;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (text_in_if.valid && text_in_if.ready) begin
			book.take_byte(text_in_if.payload);
			bytes_taken <= bytes_taken + 1;
		end
		if (class_out_if.valid && class_out_if.ready) book.check_codes(class_out_if.payload);
	end

	// Receiver: ~10% random stalls, a calm window, and one long hold-off
	// that lets a finished result back up into the input side.
	initial begin
		class_out_if.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && bytes_taken >= 650) begin
				held_off = 1'b1;
				class_out_if.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				class_out_if.ready <= (bytes_taken >= 200 && bytes_taken < 500) ||
					($urandom_range(99) >= 10);
				@(posedge clk);
			end
		end
	end

	task automatic send_byte(logic [7:0] b, logic last);
		in_beat_t beat;
		beat.text_byte = b;
		beat.last_byte = last;
		text_in_if.valid   <= 1'b1;
		text_in_if.payload <= beat;
		do @(posedge clk); while (!text_in_if.ready);
	endtask

	task automatic send_text();
		int n;
		n = text_buf.size();
		for (int i = 0; i < n; i++) begin
			send_byte(text_buf[i], i == n - 1);
			items_sent++;
			if (!(items_sent >= 800 && items_sent < 1100) && $urandom_range(99) < 10) begin
				text_in_if.valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
		text_buf.delete();
	endtask

	task automatic drain_codes();
		text_in_if.valid <= 1'b0;
		while (book.pending_codes.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic push_pattern(logic [119:0] pat, int keep);
		int n;
		n = pat_chars(pat);
		for (int i = n - 1; i >= n - keep; i--) text_buf.push_back(pat[8*i +: 8]);
	endtask

	function automatic logic [119:0] any_pattern();
		if ($urandom_range(1)) return OS_TEXT[$urandom_range(OS_COUNT - 1)];
		return BRW_TEXT[$urandom_range(BRW_COUNT - 1)];
	endfunction

	// Mostly strings made of whole or near-miss patterns mixed with filler,
	// plus some short strings of arbitrary bytes.
	task automatic build_random_text();
		int           frags;
		int           kind;
		int           n;
		int           pos;
		logic [119:0] pat;
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(255)));
			return;
		end
		frags = $urandom_range(1, 7);
		repeat (frags) begin
			kind = $urandom_range(99);
			pat = any_pattern();
			n = pat_chars(pat);
			if (kind < 45) begin
				push_pattern(pat, n);
			end else if (kind < 55) begin
				push_pattern(pat, $urandom_range(1, n - 1));
			end else if (kind < 62) begin
				pos = text_buf.size() + $urandom_range(n - 1);
				push_pattern(pat, n);
				text_buf[pos] = text_buf[pos] ^ (8'h01 << $urandom_range(7));
			end else if (kind < 92) begin
				repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end else if (kind < 97) begin
				repeat ($urandom_range(1, 2)) text_buf.push_back(8'($urandom_range(1, 255)));
			end else begin
				text_buf.push_back(8'h00);
			end
		end
	endtask

	initial begin
		book = new();
		items_sent = 0;
		bytes_taken = 0;
		held_off = 1'b0;
		drained_once = 1'b0;
		arst_n <= 1'b0;
		text_in_if.valid   <= 1'b0;
		text_in_if.payload <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-beat strings at both byte extremes
		text_buf.push_back(8'hFF);
		send_text();
		text_buf.push_back(8'h00);
		send_text();
		// pattern completed by the last byte itself
		push_pattern(BRW_TEXT[10], pat_chars(BRW_TEXT[10]));
		send_text();
		// zero byte ends matching: the browser pattern after it must not count
		push_pattern(OS_TEXT[11], pat_chars(OS_TEXT[11]));
		text_buf.push_back(8'h00);
		push_pattern(BRW_TEXT[11], pat_chars(BRW_TEXT[11]));
		send_text();
		// pattern split across two strings: history must not carry over
		push_pattern(OS_TEXT[11], 1);
		send_text();
		text_buf.push_back(8'h61);
		text_buf.push_back(8'h63);
		send_text();
		drain_codes();

		while (items_sent < TEXT_ITEMS) begin
			build_random_text();
			send_text();
			if (!drained_once && items_sent >= 900) begin
				drained_once = 1'b1;
				drain_codes();
			end
		end

		text_in_if.valid <= 1'b0;
		while (book.pending_codes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (book.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
